/* hw/rtl/limit_order_book_matcher_unit_defines.svh */
// Assertion macros for the limit order book matcher.
// Needs nothing else; included by files that check their own logic.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LOBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("order book assertion failed");
`define LOBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("order book sequencing assertion failed");
`else
`define LOBM_ASSERT(label, clk, rst, prop)
`define LOBM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/lobm_pkg.sv */
// Shared types and constants of the limit order book matcher.
// Depends on nothing; used by every module of the block.
package lobm_pkg;

   localparam int SLOTS_PER_SIDE_DEFAULT = 32;

   localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
   localparam logic [1:0] STATUS_SIDE_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO_QTY  = 2'd2;

   typedef struct packed {
      logic [31:0] order_id;
      logic        is_buy;
      logic [15:0] limit_price;
      logic [15:0] order_qty;
   } order_type;

   typedef struct packed {
      logic        is_trade;
      logic [15:0] trade_qty;
      logic [15:0] trade_price;
      logic [31:0] buyer_id;
      logic [31:0] seller_id;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [15:0] price;
      logic [15:0] remaining;
      logic [31:0] ident;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MATCH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       insert;
      logic       trade;
      logic       emit_trade;
      logic       emit_status;
      logic [1:0] status_code;
   } cmd_type;

   // Conditions the datapath reports back.
   typedef struct packed {
      logic zero_qty;
      logic side_full;
      logic crossed;
   } flags_type;

endpackage

/* hw/rtl/lobm_controller.sv */
// Sequencer of the order book matcher: check, insert, then match loop.
// Depends on lobm_pkg.
module lobm_controller #(
   parameter int SLOTS_PER_SIDE = lobm_pkg::SLOTS_PER_SIDE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lobm_pkg::flags_type flags,
   output lobm_pkg::cmd_type   cmd
);

   localparam int KW = $clog2(SLOTS_PER_SIDE + 1);

   lobm_pkg::state_type state_ff, state_in;
   logic [KW-1:0]       match_count_ff, match_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lobm_pkg::ST_IDLE;
         match_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         match_count_ff <= match_count_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      match_count_in  = match_count_ff;
      cmd             = '0;
      cmd.status_code = lobm_pkg::STATUS_ACCEPTED;
      busy            = reset || (state_ff != lobm_pkg::ST_IDLE);
      unique case (state_ff)
         lobm_pkg::ST_IDLE: begin
            if (start && !reset) begin
               cmd.load       = 1'b1;
               match_count_in = '0;
               state_in       = lobm_pkg::ST_EVAL;
            end
         end
         lobm_pkg::ST_EVAL: begin
            // The zero quantity check takes precedence over a full side.
            priority if (flags.zero_qty) begin
               cmd.emit_status = 1'b1;
               cmd.status_code = lobm_pkg::STATUS_ZERO_QTY;
               state_in        = lobm_pkg::ST_IDLE;
            end else if (flags.side_full) begin
               cmd.emit_status = 1'b1;
               cmd.status_code = lobm_pkg::STATUS_SIDE_FULL;
               state_in        = lobm_pkg::ST_IDLE;
            end else begin
               cmd.insert = 1'b1;
               state_in   = lobm_pkg::ST_MATCH;
            end
         end
         lobm_pkg::ST_MATCH: begin
            if (flags.crossed && (match_count_ff < KW'(SLOTS_PER_SIDE))) begin
               cmd.trade      = 1'b1;
               cmd.emit_trade = 1'b1;
               match_count_in = match_count_ff + KW'(1);
            end else begin
               cmd.emit_status = 1'b1;
               state_in        = lobm_pkg::ST_IDLE;
            end
         end
         default: state_in = lobm_pkg::ST_IDLE;
      endcase
   end

endmodule

/* hw/rtl/lobm_datapath.sv */
// Sorted bid and ask books as shifting register rows, plus the result word.
// Depends on lobm_pkg.
module lobm_datapath #(
   parameter int SLOTS_PER_SIDE = lobm_pkg::SLOTS_PER_SIDE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lobm_pkg::order_type  req_order,
   input  lobm_pkg::cmd_type    cmd,
   output lobm_pkg::flags_type  flags,
   output logic                 rsp_valid,
   output lobm_pkg::result_type rsp_result
);

   localparam int CW = $clog2(SLOTS_PER_SIDE + 1);

   lobm_pkg::order_type  order_ff, order_in;
   lobm_pkg::entry_type  bid_ff [SLOTS_PER_SIDE];
   lobm_pkg::entry_type  bid_in [SLOTS_PER_SIDE];
   lobm_pkg::entry_type  ask_ff [SLOTS_PER_SIDE];
   lobm_pkg::entry_type  ask_in [SLOTS_PER_SIDE];
   logic [CW-1:0]        bid_count_ff, bid_count_in;
   logic [CW-1:0]        ask_count_ff, ask_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lobm_pkg::result_type rsp_result_ff, rsp_result_in;
   logic [SLOTS_PER_SIDE-1:0] bid_keep, ask_keep;
   lobm_pkg::entry_type  new_entry;
   logic [15:0]          trade_qty;
   logic [15:0]          bid_left, ask_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         bid_count_ff <= '0;
         ask_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bid_count_ff <= bid_count_in;
         ask_count_ff <= ask_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      order_ff      <= order_in;
      rsp_result_ff <= rsp_result_in;
      for (int i = 0; i < SLOTS_PER_SIDE; i++) begin
         bid_ff[i] <= bid_in[i];
         ask_ff[i] <= ask_in[i];
      end
   end

   assign new_entry = '{price: order_ff.limit_price, remaining: order_ff.order_qty,
                        ident: order_ff.order_id};
   assign trade_qty = (bid_ff[0].remaining < ask_ff[0].remaining) ?
                      bid_ff[0].remaining : ask_ff[0].remaining;
   assign bid_left  = bid_ff[0].remaining - trade_qty;
   assign ask_left  = ask_ff[0].remaining - trade_qty;

   assign flags.zero_qty  = (order_ff.order_qty == 16'd0);
   assign flags.side_full = order_ff.is_buy ? (bid_count_ff >= CW'(SLOTS_PER_SIDE))
                                            : (ask_count_ff >= CW'(SLOTS_PER_SIDE));
   assign flags.crossed   = (bid_count_ff != '0) && (ask_count_ff != '0) &&
                            (bid_ff[0].price >= ask_ff[0].price);

   // An entry stays in place when it is valid and ranks ahead of the new order;
   // since the rows are sorted these flags form a prefix.
   always_comb begin
      for (int i = 0; i < SLOTS_PER_SIDE; i++) begin
         bid_keep[i] = (CW'(i) < bid_count_ff) && (bid_ff[i].price >= order_ff.limit_price);
         ask_keep[i] = (CW'(i) < ask_count_ff) && (ask_ff[i].price <= order_ff.limit_price);
      end
   end

   always_comb begin
      order_in      = cmd.load ? req_order : order_ff;
      bid_count_in  = bid_count_ff;
      ask_count_in  = ask_count_ff;
      rsp_valid_in  = cmd.emit_trade || cmd.emit_status;
      rsp_result_in = '0;
      for (int i = 0; i < SLOTS_PER_SIDE; i++) begin
         bid_in[i] = bid_ff[i];
         ask_in[i] = ask_ff[i];
      end

      if (cmd.insert) begin
         if (order_ff.is_buy) begin
            if (!bid_keep[0]) bid_in[0] = new_entry;
            for (int i = 1; i < SLOTS_PER_SIDE; i++) begin
               if (!bid_keep[i]) begin
                  if (bid_keep[i-1]) bid_in[i] = new_entry;
                  else bid_in[i] = bid_ff[i-1];
               end
            end
            bid_count_in = bid_count_ff + CW'(1);
         end else begin
            if (!ask_keep[0]) ask_in[0] = new_entry;
            for (int i = 1; i < SLOTS_PER_SIDE; i++) begin
               if (!ask_keep[i]) begin
                  if (ask_keep[i-1]) ask_in[i] = new_entry;
                  else ask_in[i] = ask_ff[i-1];
               end
            end
            ask_count_in = ask_count_ff + CW'(1);
         end
      end

      if (cmd.trade) begin
         if (bid_left == 16'd0) begin
            for (int i = 0; i < SLOTS_PER_SIDE - 1; i++) bid_in[i] = bid_ff[i+1];
            bid_count_in = bid_count_ff - CW'(1);
         end else begin
            bid_in[0].remaining = bid_left;
         end
         if (ask_left == 16'd0) begin
            for (int i = 0; i < SLOTS_PER_SIDE - 1; i++) ask_in[i] = ask_ff[i+1];
            ask_count_in = ask_count_ff - CW'(1);
         end else begin
            ask_in[0].remaining = ask_left;
         end
      end

      if (cmd.emit_trade) begin
         rsp_result_in.is_trade    = 1'b1;
         rsp_result_in.trade_qty   = trade_qty;
         rsp_result_in.trade_price = ask_ff[0].price;
         rsp_result_in.buyer_id    = bid_ff[0].ident;
         rsp_result_in.seller_id   = ask_ff[0].ident;
      end else if (cmd.emit_status) begin
         rsp_result_in.status = cmd.status_code;
         rsp_result_in.last   = 1'b1;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

/* hw/rtl/limit_order_book_matcher_unit.sv */
// Limit order book matcher with price-time priority.
//
// Usage: present an order word on req_order and raise start; it is taken at
// a rising edge where start is high and busy is low. Results leave on
// rsp_result, each valid for exactly one cycle while rsp_valid is high; the
// receiver cannot stall them and must take every word as it appears.
// Each order yields zero or more trade words followed by one status word
// with last set. A rejected order (zero quantity, or its side already full)
// yields just the status word.
// Sequence: the order is checked and inserted into the sorted register row
// of its side, then the match loop on the row fronts emits the trade words
// and then the status word; results lag the controller by one register.
// The unit takes no new order until busy has fallen again; a rejected
// order skips the insert and the match loop.
// Synchronous reset empties both books and returns to idle; busy is high
// during reset. Book entries hold no reset value and are read only once
// written.
`include "limit_order_book_matcher_unit_defines.svh"
module limit_order_book_matcher_unit #(
   parameter int SLOTS_PER_SIDE = lobm_pkg::SLOTS_PER_SIDE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lobm_pkg::order_type  req_order,
   output logic                 rsp_valid,
   output lobm_pkg::result_type rsp_result
);

   lobm_pkg::cmd_type   cmd;
   lobm_pkg::flags_type flags;

   lobm_controller #(.SLOTS_PER_SIDE(SLOTS_PER_SIDE)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   lobm_datapath #(.SLOTS_PER_SIDE(SLOTS_PER_SIDE)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_order  (req_order),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   `LOBM_ASSERT(a_status_last, clock, reset, rsp_valid && !rsp_result.is_trade |-> rsp_result.last)
   `LOBM_ASSERT(a_trade_mid, clock, reset, rsp_valid && rsp_result.is_trade |-> !rsp_result.last)
   `LOBM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)

endmodule
